// ===== src/dms_pkg.sv =====
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants for the drive mixer and slew limiter.
// ----------------------------------------------------------------------------
package dms_pkg;

   localparam int SPEED_WIDTH_DEF = 8;
   localparam int STEP_WIDTH      = 8;
   localparam int MASK_WIDTH      = 4;
   localparam int WHEEL_COUNT     = 4;
   localparam int CSR_IDX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   // wheel order: front left, back left, front right, back right
   localparam int WHL_FL = 0;
   localparam int WHL_BL = 1;
   localparam int WHL_FR = 2;
   localparam int WHL_BR = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SLEW_STEP    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REVERSE_MASK = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MOTOR_ENABLE = 2'd2;

   typedef enum logic [1:0] {
      ACT_RAW    = 2'd0,
      ACT_TANK   = 2'd1,
      ACT_ARCADE = 2'd2,
      ACT_HOLO   = 2'd3
   } action_type;

   // mixer to lanes
   typedef struct packed {
      logic                  update;
      logic                  load_raw;
      logic [STEP_WIDTH-1:0] slew_step;
   } lane_ctrl_type;

   // top to merge stage
   typedef struct packed {
      logic                  push;
      logic [MASK_WIDTH-1:0] reverse_mask;
      logic [MASK_WIDTH-1:0] motor_enable;
   } merge_ctrl_type;

endpackage

// ===== src/dms_mixer.sv =====
// ----------------------------------------------------------------------------
// dms_mixer
// Mixes the request operands into four saturated wheel targets and
// saturates the raw wheel speeds.
// ----------------------------------------------------------------------------
module dms_mixer #(
   parameter int SPEED_WIDTH = dms_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                push,
   input  logic [1:0]                          action,
   input  logic [dms_pkg::STEP_WIDTH-1:0]      slew_step,
   input  logic signed [SPEED_WIDTH-1:0]       raw_speed [dms_pkg::WHEEL_COUNT],
   input  logic signed [SPEED_WIDTH-1:0]       left_speed,
   input  logic signed [SPEED_WIDTH-1:0]       right_speed,
   input  logic signed [SPEED_WIDTH-1:0]       forward_speed,
   input  logic signed [SPEED_WIDTH-1:0]       turn_speed,
   input  logic signed [SPEED_WIDTH-1:0]       strafe_speed,
   output logic signed [SPEED_WIDTH-1:0]       raw_sat [dms_pkg::WHEEL_COUNT],
   output logic signed [SPEED_WIDTH-1:0]       target [dms_pkg::WHEEL_COUNT],
   output dms_pkg::lane_ctrl_type              lane_ctrl
);
   import dms_pkg::*;

   localparam int SW = SPEED_WIDTH + 2;
   localparam logic signed [SW-1:0] WIDE_MAX = SW'((1 << (SPEED_WIDTH - 1)) - 1);
   localparam logic signed [SW-1:0] WIDE_MIN = -WIDE_MAX;
   localparam logic signed [SPEED_WIDTH-1:0] NEG_FULL = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
   localparam logic signed [SPEED_WIDTH-1:0] NEG_MAX  = NEG_FULL + SPEED_WIDTH'(1);

   action_type             act;
   logic signed [SW-1:0]   f_w, t_w, s_w, l_w, r_w;
   logic signed [SW-1:0]   mix [WHEEL_COUNT];

   assign act = action_type'(action);
   assign f_w = {{2{forward_speed[SPEED_WIDTH-1]}}, forward_speed};
   assign t_w = {{2{turn_speed[SPEED_WIDTH-1]}}, turn_speed};
   assign s_w = {{2{strafe_speed[SPEED_WIDTH-1]}}, strafe_speed};
   assign l_w = {{2{left_speed[SPEED_WIDTH-1]}}, left_speed};
   assign r_w = {{2{right_speed[SPEED_WIDTH-1]}}, right_speed};

   always_comb begin
      case (act)
         ACT_TANK: begin
            mix[WHL_FL] = l_w;
            mix[WHL_BL] = l_w;
            mix[WHL_FR] = r_w;
            mix[WHL_BR] = r_w;
         end
         ACT_ARCADE: begin
            mix[WHL_FL] = f_w - t_w;
            mix[WHL_BL] = f_w - t_w;
            mix[WHL_FR] = f_w + t_w;
            mix[WHL_BR] = f_w + t_w;
         end
         ACT_HOLO: begin
            mix[WHL_FL] = f_w + t_w + s_w;
            mix[WHL_BL] = f_w + t_w - s_w;
            mix[WHL_FR] = f_w - t_w - s_w;
            mix[WHL_BR] = f_w - t_w + s_w;
         end
         default: begin
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               mix[i] = '0;
            end
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         if (mix[i] > WIDE_MAX) begin
            target[i] = WIDE_MAX[SPEED_WIDTH-1:0];
         end else if (mix[i] < WIDE_MIN) begin
            target[i] = WIDE_MIN[SPEED_WIDTH-1:0];
         end else begin
            target[i] = mix[i][SPEED_WIDTH-1:0];
         end
         // most negative code folds to the negative limit
         raw_sat[i] = (raw_speed[i] == NEG_FULL) ? NEG_MAX : raw_speed[i];
      end
   end

   assign lane_ctrl.update    = push;
   assign lane_ctrl.load_raw  = (act == ACT_RAW);
   assign lane_ctrl.slew_step = slew_step;

endmodule

// ===== src/dms_lane.sv =====
// ----------------------------------------------------------------------------
// dms_lane
// One wheel: holds the last speed and steps it toward the target by at most the slew step
// (a zero step jumps to the target), or loads the raw speed in raw mode.
// ----------------------------------------------------------------------------
module dms_lane #(
   parameter int SPEED_WIDTH = dms_pkg::SPEED_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dms_pkg::lane_ctrl_type        lane_ctrl,
   input  logic signed [SPEED_WIDTH-1:0] raw_sat,
   input  logic signed [SPEED_WIDTH-1:0] target,
   output logic signed [SPEED_WIDTH-1:0] speed_next
);
   import dms_pkg::*;

   localparam int GW = SPEED_WIDTH + 1;
   localparam int MW = SPEED_WIDTH + 2;
   localparam logic signed [MW-1:0] WIDE_MAX = MW'((1 << (SPEED_WIDTH - 1)) - 1);
   localparam logic signed [MW-1:0] WIDE_MIN = -WIDE_MAX;

   logic signed [SPEED_WIDTH-1:0] last_ff, last_in;
   logic signed [GW-1:0]          gap;
   logic [GW-1:0]                 gap_abs;
   logic [GW-1:0]                 step_g;
   logic signed [MW-1:0]          step_m;
   logic signed [MW-1:0]          cur_m;
   logic signed [MW-1:0]          moved;
   logic signed [SPEED_WIDTH-1:0] slewed;

   assign gap     = {last_ff[SPEED_WIDTH-1], last_ff} - {target[SPEED_WIDTH-1], target};
   assign gap_abs = (gap < 0) ? -gap : gap;
   assign step_g  = {{(GW-STEP_WIDTH){1'b0}}, lane_ctrl.slew_step};
   assign step_m  = {{(MW-STEP_WIDTH){1'b0}}, lane_ctrl.slew_step};
   assign cur_m   = {{2{last_ff[SPEED_WIDTH-1]}}, last_ff};
   assign moved   = (last_ff > target) ? cur_m - step_m : cur_m + step_m;

   always_comb begin
      if (lane_ctrl.slew_step == '0 || gap_abs < step_g) begin
         slewed = target;
      end else if (moved > WIDE_MAX) begin
         slewed = WIDE_MAX[SPEED_WIDTH-1:0];
      end else if (moved < WIDE_MIN) begin
         slewed = WIDE_MIN[SPEED_WIDTH-1:0];
      end else begin
         slewed = moved[SPEED_WIDTH-1:0];
      end
   end

   always_comb begin
      if (!lane_ctrl.update) begin
         last_in = last_ff;
      end else if (lane_ctrl.load_raw) begin
         last_in = raw_sat;
      end else begin
         last_in = slewed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   assign speed_next = last_in;

endmodule

// ===== src/dms_merge.sv =====
// ----------------------------------------------------------------------------
// dms_merge
// Combines the lane speeds into one response: reversal, enable gating,
// and a two-entry output buffer (output register plus skid register).
// ----------------------------------------------------------------------------
module dms_merge #(
   parameter int SPEED_WIDTH = dms_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dms_pkg::merge_ctrl_type              merge_ctrl,
   input  logic signed [SPEED_WIDTH-1:0]        speed [dms_pkg::WHEEL_COUNT],
   output logic                                 req_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SPEED_WIDTH-1:0]        rsp_speed [dms_pkg::WHEEL_COUNT],
   output logic [dms_pkg::MASK_WIDTH-1:0]       rsp_drive_valid
);
   import dms_pkg::*;

   logic signed [SPEED_WIDTH-1:0] item_speed [WHEEL_COUNT];
   logic signed [SPEED_WIDTH-1:0] main_speed_ff [WHEEL_COUNT];
   logic signed [SPEED_WIDTH-1:0] skid_speed_ff [WHEEL_COUNT];
   logic [MASK_WIDTH-1:0]         main_drive_ff, skid_drive_ff;
   logic                          main_valid_ff, skid_valid_ff;

   always_comb begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         if (!merge_ctrl.motor_enable[i]) begin
            item_speed[i] = '0;
         end else if (merge_ctrl.reverse_mask[i]) begin
            item_speed[i] = -speed[i];
         end else begin
            item_speed[i] = speed[i];
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || rsp_ready) begin
         // no push can arrive while the skid entry is occupied
         main_valid_ff <= skid_valid_ff || merge_ctrl.push;
         skid_valid_ff <= 1'b0;
      end else if (merge_ctrl.push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            main_speed_ff <= skid_speed_ff;
            main_drive_ff <= skid_drive_ff;
         end else begin
            main_speed_ff <= item_speed;
            main_drive_ff <= merge_ctrl.motor_enable;
         end
      end else if (merge_ctrl.push) begin
         skid_speed_ff <= item_speed;
         skid_drive_ff <= merge_ctrl.motor_enable;
      end
   end

   assign req_ready       = !skid_valid_ff;
   assign rsp_valid       = main_valid_ff;
   assign rsp_speed       = main_speed_ff;
   assign rsp_drive_valid = main_drive_ff;

endmodule

// ===== src/drive_mixer_slew_limiter_core.sv =====
// ----------------------------------------------------------------------------
// drive_mixer_slew_limiter_core
// Responses are registered in the output register, or in the skid register while
//   the previous response waits. Throughput: one request per cycle while req_ready
//   is high; the four wheel lanes update their stored speeds in the accept cycle, and
//   the two-entry output buffer takes one more request while one response waits.
// Reset: clears the registers, the stored wheel speeds and the buffer.
// ----------------------------------------------------------------------------
module drive_mixer_slew_limiter_core #(
   parameter int SPEED_WIDTH = dms_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_action,
   input  logic signed [SPEED_WIDTH-1:0]        req_raw_front_left,
   input  logic signed [SPEED_WIDTH-1:0]        req_raw_back_left,
   input  logic signed [SPEED_WIDTH-1:0]        req_raw_front_right,
   input  logic signed [SPEED_WIDTH-1:0]        req_raw_back_right,
   input  logic signed [SPEED_WIDTH-1:0]        req_left_speed,
   input  logic signed [SPEED_WIDTH-1:0]        req_right_speed,
   input  logic signed [SPEED_WIDTH-1:0]        req_forward_speed,
   input  logic signed [SPEED_WIDTH-1:0]        req_turn_speed,
   input  logic signed [SPEED_WIDTH-1:0]        req_strafe_speed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SPEED_WIDTH-1:0]        rsp_out_front_left,
   output logic signed [SPEED_WIDTH-1:0]        rsp_out_back_left,
   output logic signed [SPEED_WIDTH-1:0]        rsp_out_front_right,
   output logic signed [SPEED_WIDTH-1:0]        rsp_out_back_right,
   output logic [dms_pkg::MASK_WIDTH-1:0]       rsp_drive_valid,
   input  logic                                 csr_write_en,
   input  logic [dms_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [dms_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import dms_pkg::*;

   logic [STEP_WIDTH-1:0]         slew_step_ff;
   logic [MASK_WIDTH-1:0]         reverse_mask_ff;
   logic [MASK_WIDTH-1:0]         motor_enable_ff;
   logic                          push;
   logic signed [SPEED_WIDTH-1:0] raw_speed [WHEEL_COUNT];
   logic signed [SPEED_WIDTH-1:0] raw_sat [WHEEL_COUNT];
   logic signed [SPEED_WIDTH-1:0] target [WHEEL_COUNT];
   logic signed [SPEED_WIDTH-1:0] speed_next [WHEEL_COUNT];
   logic signed [SPEED_WIDTH-1:0] rsp_speed [WHEEL_COUNT];
   lane_ctrl_type                 lane_ctrl;
   merge_ctrl_type                merge_ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_step_ff    <= '0;
         reverse_mask_ff <= '0;
         motor_enable_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SLEW_STEP:    slew_step_ff    <= csr_wdata[STEP_WIDTH-1:0];
            CSR_REVERSE_MASK: reverse_mask_ff <= csr_wdata[MASK_WIDTH-1:0];
            CSR_MOTOR_ENABLE: motor_enable_ff <= csr_wdata[MASK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign push = req_valid && req_ready;

   assign raw_speed[WHL_FL] = req_raw_front_left;
   assign raw_speed[WHL_BL] = req_raw_back_left;
   assign raw_speed[WHL_FR] = req_raw_front_right;
   assign raw_speed[WHL_BR] = req_raw_back_right;

   dms_mixer #(
      .SPEED_WIDTH (SPEED_WIDTH)
   ) u_mixer (
      .push          (push),
      .action        (req_action),
      .slew_step     (slew_step_ff),
      .raw_speed     (raw_speed),
      .left_speed    (req_left_speed),
      .right_speed   (req_right_speed),
      .forward_speed (req_forward_speed),
      .turn_speed    (req_turn_speed),
      .strafe_speed  (req_strafe_speed),
      .raw_sat       (raw_sat),
      .target        (target),
      .lane_ctrl     (lane_ctrl)
   );

   for (genvar g = 0; g < WHEEL_COUNT; g++) begin : g_lane
      dms_lane #(
         .SPEED_WIDTH (SPEED_WIDTH)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .lane_ctrl  (lane_ctrl),
         .raw_sat    (raw_sat[g]),
         .target     (target[g]),
         .speed_next (speed_next[g])
      );
   end

   assign merge_ctrl.push         = push;
   assign merge_ctrl.reverse_mask = reverse_mask_ff;
   assign merge_ctrl.motor_enable = motor_enable_ff;

   dms_merge #(
      .SPEED_WIDTH (SPEED_WIDTH)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .merge_ctrl      (merge_ctrl),
      .speed           (speed_next),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed       (rsp_speed),
      .rsp_drive_valid (rsp_drive_valid)
   );

   assign rsp_out_front_left  = rsp_speed[WHL_FL];
   assign rsp_out_back_left   = rsp_speed[WHL_BL];
   assign rsp_out_front_right = rsp_speed[WHL_FR];
   assign rsp_out_back_right  = rsp_speed[WHL_BR];

endmodule
